FILE: sv/deq_pkg.sv
// Shared types and constants for the double-ended queue.
// No dependencies; compiled first.
package deq_pkg;

    localparam int TYPE_W = 3;
    localparam int DATA_W = 32;
    localparam int STAT_W = 2;

    // request codes on the input channel
    localparam logic [TYPE_W-1:0] REQ_PUSH_FRONT = 3'd0;
    localparam logic [TYPE_W-1:0] REQ_PUSH_BACK  = 3'd1;
    localparam logic [TYPE_W-1:0] REQ_POP_FRONT  = 3'd2;
    localparam logic [TYPE_W-1:0] REQ_POP_BACK   = 3'd3;
    localparam logic [TYPE_W-1:0] REQ_LIST_FWD   = 3'd4;
    localparam logic [TYPE_W-1:0] REQ_LIST_REV   = 3'd5;

    // result status codes
    localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_PUSH_FRONT,
        OP_PUSH_BACK,
        OP_POP_FRONT,
        OP_POP_BACK,
        OP_LIST_NEXT,
        OP_REPORT
    } t_op;

    // controller -> datapath
    typedef struct packed {
        t_op               op;
        logic              list_init;
        logic              reverse;
        logic [STAT_W-1:0] status;
    } t_dp_cmd;

    // datapath -> controller
    typedef struct packed {
        logic empty;
        logic full;
        logic list_last;
        logic can_issue;
    } t_dp_stat;

endpackage

FILE: sv/deq_ifs.sv
// Valid/ready channel interfaces for requests and results.
// Depends on deq_pkg for field widths.
interface deq_req_if import deq_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic [TYPE_W-1:0]        req_type;
    logic signed [DATA_W-1:0] value;

    modport source (output valid, req_type, value, input ready);
    modport sink   (input valid, req_type, value, output ready);
endinterface

interface deq_rsp_if import deq_pkg::*; #(parameter int CNT_W = 5) ();
    logic                     valid;
    logic                     ready;
    logic signed [DATA_W-1:0] data;
    logic [STAT_W-1:0]        status;
    logic                     last;
    logic [CNT_W-1:0]         count;

    modport source (output valid, data, status, last, count, input ready);
    modport sink   (input valid, data, status, last, count, output ready);
endinterface

FILE: sv/deq_ctrl.sv
// Request decoder and listing sequencer for the double-ended queue.
// Depends on deq_pkg; drives deq_dp through t_dp_cmd.
module deq_ctrl import deq_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_req_valid,
    input  logic [TYPE_W-1:0] i_req_type,
    output logic              o_req_ready,
    input  t_dp_stat          i_stat,
    output t_dp_cmd           o_cmd
);

    typedef enum logic {
        S_IDLE,
        S_LIST
    } t_state;

    t_state r_state, n_state;
    logic   r_reverse, n_reverse;
    logic   accept;

    assign o_req_ready = (r_state == S_IDLE) && i_stat.can_issue;
    assign accept      = i_req_valid && o_req_ready;

    always_comb begin
        n_state          = r_state;
        n_reverse        = r_reverse;
        o_cmd.op         = OP_NONE;
        o_cmd.list_init  = 1'b0;
        o_cmd.reverse    = r_reverse;
        o_cmd.status     = ST_OK;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    case (i_req_type)
                        REQ_PUSH_FRONT, REQ_PUSH_BACK: begin
                            if (i_stat.full) begin
                                o_cmd.op     = OP_REPORT;
                                o_cmd.status = ST_FULL;
                            end else begin
                                o_cmd.op = (i_req_type == REQ_PUSH_FRONT) ?
                                           OP_PUSH_FRONT : OP_PUSH_BACK;
                            end
                        end
                        REQ_POP_FRONT, REQ_POP_BACK: begin
                            if (i_stat.empty) begin
                                o_cmd.op     = OP_REPORT;
                                o_cmd.status = ST_EMPTY;
                            end else begin
                                o_cmd.op = (i_req_type == REQ_POP_FRONT) ?
                                           OP_POP_FRONT : OP_POP_BACK;
                            end
                        end
                        REQ_LIST_FWD, REQ_LIST_REV: begin
                            if (i_stat.empty) begin
                                o_cmd.op     = OP_REPORT;
                                o_cmd.status = ST_EMPTY;
                            end else begin
                                o_cmd.list_init = 1'b1;
                                n_reverse       = (i_req_type == REQ_LIST_REV);
                                n_state         = S_LIST;
                            end
                        end
                        default: begin
                            // unused codes answer ok with nothing changed
                            o_cmd.op = OP_REPORT;
                        end
                    endcase
                end
            end
            S_LIST: begin
                if (i_stat.can_issue) begin
                    o_cmd.op = OP_LIST_NEXT;
                    if (i_stat.list_last) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_reverse <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_reverse <= n_reverse;
        end
    end

    a_list_blocks_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_LIST) |-> !o_req_ready)
        else $error("request accepted during listing");

    a_list_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.list_init |=> (r_state == S_LIST))
        else $error("listing started without entering list state");

    a_list_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_LIST && o_cmd.op == OP_LIST_NEXT && i_stat.list_last)
        |=> (r_state == S_IDLE))
        else $error("listing did not end after last entry");

endmodule

FILE: sv/deq_dp.sv
// Datapath: ring store, front/occupancy registers, listing cursor,
// read stage and two-beat result queue. Depends on deq_pkg.
module deq_dp import deq_pkg::*; #(
    parameter int DEPTH = 16,
    localparam int IDX_W = $clog2(DEPTH),
    localparam int CNT_W = $clog2(DEPTH + 1)
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_dp_cmd                  i_cmd,
    input  logic signed [DATA_W-1:0] i_value,
    output t_dp_stat                 o_stat,
    output logic                     o_rsp_valid,
    input  logic                     i_rsp_ready,
    output logic signed [DATA_W-1:0] o_rsp_data,
    output logic [STAT_W-1:0]        o_rsp_status,
    output logic                     o_rsp_last,
    output logic [CNT_W-1:0]         o_rsp_count
);

    localparam int FIFO_W = DATA_W + STAT_W + 1 + CNT_W;

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rd_data;

    logic [IDX_W-1:0]  r_front, n_front;
    logic [CNT_W-1:0]  r_occ, n_occ;
    logic [CNT_W-1:0]  r_cur, n_cur;

    logic              wr_en, rd_en;
    logic [IDX_W-1:0]  wr_addr, rd_addr;
    logic [IDX_W-1:0]  front_dec;
    logic [CNT_W-1:0]  list_off;

    logic              r_s1_valid, n_s1_valid;
    logic              r_s1_use_mem, n_s1_use_mem;
    logic [STAT_W-1:0] r_s1_status, n_s1_status;
    logic              r_s1_last, n_s1_last;
    logic [CNT_W-1:0]  r_s1_count, n_s1_count;

    logic [FIFO_W-1:0] r_fifo [2];
    logic              r_wp, r_rp;
    logic [1:0]        r_lvl;
    logic              fifo_wr, fifo_rd;
    logic [FIFO_W-1:0] fifo_head;
    logic [DATA_W-1:0] s1_data;
    logic [2:0]        credit;

    // base + off modulo DEPTH, with base < DEPTH and off < DEPTH
    function automatic logic [IDX_W-1:0] ring_add(input logic [IDX_W-1:0] base,
                                                  input logic [CNT_W-1:0] off);
        logic [CNT_W:0] sum;
        sum = {{(CNT_W + 1 - IDX_W){1'b0}}, base} + {1'b0, off};
        if (sum >= (CNT_W + 1)'(DEPTH)) begin
            sum = sum - (CNT_W + 1)'(DEPTH);
        end
        return sum[IDX_W-1:0];
    endfunction

    assign front_dec = (r_front == '0) ? IDX_W'(DEPTH - 1) : r_front - 1'b1;
    assign list_off  = i_cmd.reverse ? (r_occ - CNT_W'(1) - r_cur) : r_cur;

    always_comb begin
        n_front      = r_front;
        n_occ        = r_occ;
        n_cur        = r_cur;
        wr_en        = 1'b0;
        rd_en        = 1'b0;
        wr_addr      = '0;
        rd_addr      = '0;
        n_s1_valid   = 1'b0;
        n_s1_use_mem = 1'b0;
        n_s1_status  = ST_OK;
        n_s1_last    = 1'b1;
        if (i_cmd.list_init) begin
            n_cur = '0;
        end
        case (i_cmd.op)
            OP_PUSH_FRONT: begin
                wr_en      = 1'b1;
                wr_addr    = front_dec;
                n_front    = front_dec;
                n_occ      = r_occ + CNT_W'(1);
                n_s1_valid = 1'b1;
            end
            OP_PUSH_BACK: begin
                wr_en      = 1'b1;
                wr_addr    = ring_add(r_front, r_occ);
                n_occ      = r_occ + CNT_W'(1);
                n_s1_valid = 1'b1;
            end
            OP_POP_FRONT: begin
                rd_en        = 1'b1;
                rd_addr      = r_front;
                n_occ        = r_occ - CNT_W'(1);
                n_front      = (n_occ == '0) ? '0 : ring_add(r_front, CNT_W'(1));
                n_s1_valid   = 1'b1;
                n_s1_use_mem = 1'b1;
            end
            OP_POP_BACK: begin
                rd_en        = 1'b1;
                rd_addr      = ring_add(r_front, r_occ - CNT_W'(1));
                n_occ        = r_occ - CNT_W'(1);
                n_front      = (n_occ == '0) ? '0 : r_front;
                n_s1_valid   = 1'b1;
                n_s1_use_mem = 1'b1;
            end
            OP_LIST_NEXT: begin
                rd_en        = 1'b1;
                rd_addr      = ring_add(r_front, list_off);
                n_cur        = r_cur + CNT_W'(1);
                n_s1_valid   = 1'b1;
                n_s1_use_mem = 1'b1;
                n_s1_last    = (r_cur + CNT_W'(1) == r_occ);
            end
            OP_REPORT: begin
                n_s1_valid  = 1'b1;
                n_s1_status = i_cmd.status;
            end
            default: begin
            end
        endcase
        n_s1_count = n_occ;
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= i_value;
        end
        if (rd_en) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_front    <= '0;
            r_occ      <= '0;
            r_cur      <= '0;
            r_s1_valid <= 1'b0;
        end else begin
            r_front    <= n_front;
            r_occ      <= n_occ;
            r_cur      <= n_cur;
            r_s1_valid <= n_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_use_mem <= n_s1_use_mem;
        r_s1_status  <= n_s1_status;
        r_s1_last    <= n_s1_last;
        r_s1_count   <= n_s1_count;
    end

    // result queue: two beats so a waiting result does not stall the store
    assign s1_data   = r_s1_use_mem ? r_rd_data : '0;
    assign fifo_wr   = r_s1_valid;
    assign fifo_rd   = o_rsp_valid && i_rsp_ready;
    assign fifo_head = r_fifo[r_rp];

    always_ff @(posedge i_clk) begin
        if (fifo_wr) begin
            r_fifo[r_wp] <= {s1_data, r_s1_status, r_s1_last, r_s1_count};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_lvl <= '0;
        end else begin
            if (fifo_wr) begin
                r_wp <= ~r_wp;
            end
            if (fifo_rd) begin
                r_rp <= ~r_rp;
            end
            r_lvl <= r_lvl + {1'b0, fifo_wr} - {1'b0, fifo_rd};
        end
    end

    assign o_rsp_valid  = (r_lvl != '0);
    assign o_rsp_data   = fifo_head[FIFO_W-1 -: DATA_W];
    assign o_rsp_status = fifo_head[CNT_W + 1 +: STAT_W];
    assign o_rsp_last   = fifo_head[CNT_W];
    assign o_rsp_count  = fifo_head[CNT_W-1:0];

    // a new beat may start when the queue has room once the staged one lands
    assign credit           = {1'b0, r_lvl} + {2'b0, r_s1_valid};
    assign o_stat.can_issue = credit < (3'd2 + {2'b0, fifo_rd});
    assign o_stat.empty     = (r_occ == '0);
    assign o_stat.full      = (r_occ == CNT_W'(DEPTH));
    assign o_stat.list_last = (r_cur + CNT_W'(1) == r_occ);

    a_fifo_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_lvl == 2'd2) |-> (!fifo_wr || fifo_rd))
        else $error("result queue overflow");

    a_occ_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_occ <= CNT_W'(DEPTH))
        else $error("occupancy above depth");

    a_read_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rd_en |-> (r_occ != '0))
        else $error("store read while empty");

    a_push_not_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        wr_en |=> (r_occ != '0) && ($past(r_occ) != CNT_W'(DEPTH)))
        else $error("push into full store");

endmodule

FILE: sv/double_ended_queue.sv
// Bounded double-ended queue of signed 32-bit values in a DEPTH-entry ring.
// Channels: i_req (valid/ready; req_type, value) carries requests, o_rsp
// (valid/ready; data, status, last, count) carries results. A beat moves on
// a rising edge with valid and ready both high.
// Push, pop and error requests give one result each; the store read is
// registered, then the beat enters a two-beat result queue.
// These requests are taken one per cycle while the result queue has room.
// A listing of N entries gives N beats, one per cycle while the result queue
// has room, paced by the single read port of the store; no request is taken
// until its last entry has been read.
// The final beat of each request has last set.
// Reset (synchronous, active low) empties the queue and the result queue;
// store contents are not cleared and need no clearing pass.
// When the receiver stalls, up to two beats wait in the result queue and
// i_req.ready falls; listings pause and resume without loss.
// Depends on deq_pkg, deq_ifs, deq_ctrl and deq_dp.
module double_ended_queue import deq_pkg::*; #(
    parameter int DEPTH = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    deq_req_if.sink    i_req,
    deq_rsp_if.source  o_rsp
);

    localparam int CNT_W = $clog2(DEPTH + 1);

    t_dp_cmd          cmd;
    t_dp_stat         stat;
    logic [CNT_W-1:0] rsp_count;

    deq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .i_req_type  (i_req.req_type),
        .o_req_ready (i_req.ready),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    deq_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .i_value      (i_req.value),
        .o_stat       (stat),
        .o_rsp_valid  (o_rsp.valid),
        .i_rsp_ready  (o_rsp.ready),
        .o_rsp_data   (o_rsp.data),
        .o_rsp_status (o_rsp.status),
        .o_rsp_last   (o_rsp.last),
        .o_rsp_count  (rsp_count)
    );

    assign o_rsp.count = rsp_count;

endmodule
